>>> src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PLSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, also checked through reset.
`define PLSC_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/plsc_pkg.sv
package plsc_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_PRESENCE = 3'd1;
    localparam logic [2:0] OP_FREE     = 3'd2;
    localparam logic [2:0] OP_NORMAL   = 3'd3;
    localparam logic [2:0] OP_SWITCH   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_DUTY_OFF     = 2'd0;
    localparam logic [1:0] REG_DUTY_ON      = 2'd1;
    localparam logic [1:0] REG_DUTY_STANDBY = 2'd2;

    // Timing constants in 0.1 ms ticks.
    localparam logic [4:0]  PWM_STEPS     = 5'd25;
    localparam logic [11:0] HOLD_TICKS    = 12'd3000;
    localparam logic [14:0] ABSENCE_TICKS = 15'd30000;
    localparam logic [11:0] NORMAL_PERIOD = 12'd3000;
    localparam logic [11:0] FREE_PERIOD   = 12'd500;

    typedef struct packed {
        logic [2:0] op;
        logic       present;
        logic [7:0] value;
    } plsc_item_t;

    typedef struct packed {
        logic [7:0] duty_off;
        logic [7:0] duty_on;
        logic [7:0] duty_standby;
    } plsc_cfg_t;

    // Packed so that servo_level lands in bit 0.
    typedef struct packed {
        logic [7:0] duty_now;
        logic       mode_now;
        logic       notify;
        logic [7:0] switch_now;
        logic       light_on;
        logic       servo_level;
    } plsc_res_t;

endpackage

>>> src/plsc_core.sv
module plsc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  plsc_pkg::plsc_item_t item,
    input  plsc_pkg::plsc_cfg_t  cfg,
    output plsc_pkg::plsc_res_t  res
);
    import plsc_pkg::*;

    logic [4:0]  phase_reg, phase_next;
    logic [7:0]  duty_reg, duty_next;
    logic [11:0] hold_reg, hold_next;
    logic [14:0] absent_reg, absent_next;
    logic [11:0] routine_reg, routine_next;
    logic        light_reg, light_next;
    logic [7:0]  switch_reg, switch_next;
    logic        mode_reg, mode_next;
    logic        present_reg, present_next;
    logic        notify;
    logic [4:0]  phase_inc;

    // One item's state update: counters, routine, PWM phase, standby return, presence, mode and switch.
    always_comb begin
        phase_next   = phase_reg;
        duty_next    = duty_reg;
        hold_next    = hold_reg;
        absent_next  = absent_reg;
        routine_next = routine_reg;
        light_next   = light_reg;
        switch_next  = switch_reg;
        mode_next    = mode_reg;
        present_next = present_reg;
        notify       = 1'b0;
        phase_inc    = phase_reg + 5'd1;
        unique case (item.op)
            OP_TICK: begin
                // Saturating counters.
                hold_next    = (hold_reg != '1) ? hold_reg + 12'd1 : hold_reg;
                absent_next  = (absent_reg != '1) ? absent_reg + 15'd1 : absent_reg;
                routine_next = (routine_reg != '1) ? routine_reg + 12'd1 : routine_reg;
                if (routine_next >= (mode_reg ? FREE_PERIOD : NORMAL_PERIOD)) begin
                    routine_next = '0;
                    if (!mode_reg) begin
                        if (!present_reg) begin
                            if (absent_next > ABSENCE_TICKS) begin
                                light_next = 1'b0;
                                if (switch_reg == 8'd0) begin
                                    switch_next = 8'd1;
                                end
                                notify = 1'b1;
                            end
                        end else begin
                            absent_next = '0;
                            light_next  = (switch_reg != 8'd0);
                        end
                        if (light_next != light_reg) begin
                            duty_next = light_next ? cfg.duty_on : cfg.duty_off;
                            hold_next = '0;
                        end
                    end else begin
                        duty_next = switch_reg;
                        hold_next = '0;
                    end
                end
                phase_next = (phase_inc >= PWM_STEPS) ? 5'd0 : phase_inc;
                if (!mode_reg && hold_next > HOLD_TICKS) begin
                    duty_next = cfg.duty_standby;
                end
            end
            OP_PRESENCE: present_next = item.present;
            OP_FREE: begin
                mode_next    = 1'b1;
                routine_next = '0;
            end
            OP_NORMAL: begin
                mode_next    = 1'b0;
                routine_next = '0;
            end
            OP_SWITCH: switch_next = item.value;
            default: ;
        endcase
    end

    // Result fields seen after this item.
    always_comb begin
        res.servo_level = ({3'b000, phase_next} < duty_next);
        res.light_on    = light_next;
        res.switch_now  = switch_next;
        res.notify      = notify;
        res.mode_now    = mode_next;
        res.duty_now    = duty_next;
    end

    // State registers advance once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            duty_reg    <= '0;
            hold_reg    <= '0;
            absent_reg  <= '0;
            routine_reg <= '0;
            light_reg   <= 1'b0;
            switch_reg  <= 8'd1;
            mode_reg    <= 1'b0;
            present_reg <= 1'b0;
        end else if (en) begin
            phase_reg   <= phase_next;
            duty_reg    <= duty_next;
            hold_reg    <= hold_next;
            absent_reg  <= absent_next;
            routine_reg <= routine_next;
            light_reg   <= light_next;
            switch_reg  <= switch_next;
            mode_reg    <= mode_next;
            present_reg <= present_next;
        end
    end

endmodule

>>> src/presence_light_servo_controller_unit.sv
// Servo PWM and light controller with a presence timeout.
// Input stream: one word per event. s_tuser carries the operation (tick,
// presence report, enter free rotation, enter normal, set remote switch) and
// s_tdata carries the presence flag and the new switch value.
// Output stream: exactly one word per input word, holding the servo pin
// level, the light decision, the switch value, the notify pulse, the mode
// and the current duty after that event.
// Configuration: cfg_wr_en with cfg_index 0, 1 or 2 writes the off, on and
// standby duties; write only while no word is in flight.
// An accepted word sits in the input register while the state update runs,
// and its result is loaded into the output register when that register is
// free or draining.
// Throughput is one word per cycle while the output is not stalled; the state
// update for a word completes in the cycle it leaves the input register.
// Reset (synchronous, aresetn low) empties both registers and returns the
// state to light off, normal mode, switch value one and duty zero.
// When the receiver holds m_tready low, the output word stays put, the
// input register fills, and s_tready then drops until the output drains.
module presence_light_servo_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // present, value[7:0], zero fill
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // servo_level, light_on, switch_now[7:0], notify,
                                   // mode_now, duty_now[7:0], zero fill
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import plsc_pkg::*;

    logic       in_valid_reg;
    plsc_item_t in_item_reg;
    logic       out_valid_reg;
    plsc_res_t  out_res_reg;
    plsc_cfg_t  cfg_reg;
    plsc_res_t  core_res;
    logic       advance;

    // The input word moves on when the output register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DUTY_OFF:     cfg_reg.duty_off     <= cfg_data;
                REG_DUTY_ON:      cfg_reg.duty_on      <= cfg_data;
                REG_DUTY_STANDBY: cfg_reg.duty_standby <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op      <= s_tuser;
            in_item_reg.present <= s_tdata[0];
            in_item_reg.value   <= s_tdata[8:1];
        end
    end

    plsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

endmodule

>>> src/plsc_checker.sv
`include "assert_macros.svh"

module plsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    // The pin is only high while the duty is nonzero.
    `PLSC_ASSERT_IMP(a_level_needs_duty, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[19:12] != 8'd0)
    // The absence timeout fires only in normal mode, leaves the light off
    // and the switch nonzero.
    `PLSC_ASSERT_IMP(a_notify_normal, aclk, aresetn, m_tvalid && m_tdata[10], !m_tdata[11] && !m_tdata[1])
    `PLSC_ASSERT_IMP(a_notify_switch, aclk, aresetn, m_tvalid && m_tdata[10], m_tdata[9:2] != 8'd0)
    // Reset empties the output side.
    `PLSC_ASSERT_NXT(a_reset_empty, aclk, !aresetn, !m_tvalid)
    // A stalled output word stays offered.
    `PLSC_ASSERT_IMP(a_hold_valid, aclk, aresetn, $past(m_tvalid && !m_tready) && $past(aresetn), m_tvalid)

endmodule

bind presence_light_servo_controller_unit plsc_checker u_plsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
